// ===== src/iphpc_pkg.sv =====
// shared types, constants and the payload method matcher for the ipv4 header parser
// no dependencies
package iphpc_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned QUEUE_AW         = 1;

  localparam logic [15:0] WEB_PORT_RST        = 16'd80;
  localparam logic [15:0] SECURE_WEB_PORT_RST = 16'd443;

  localparam logic [3:0] IP_VER4 = 4'd4;
  localparam logic [3:0] IP_VER6 = 4'd6;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [3:0] NIBBLE_MASK = 4'h0F;

  localparam logic [2:0] KIND_UNKNOWN  = 3'd0;
  localparam logic [2:0] KIND_TCP      = 3'd1;
  localparam logic [2:0] KIND_TCP_DATA = 3'd2;
  localparam logic [2:0] KIND_UDP_DATA = 3'd3;
  localparam logic [2:0] KIND_V6       = 3'd4;

  localparam logic [1:0] APP_NONE   = 2'd0;
  localparam logic [1:0] APP_WEB    = 2'd1;
  localparam logic [1:0] APP_SECURE = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic REG_WEB_PORT        = 1'b0;
  localparam logic REG_SECURE_WEB_PORT = 1'b1;

  localparam logic [23:0] MTH_GET    = "GET";
  localparam logic [31:0] MTH_POST   = "POST";
  localparam logic [31:0] MTH_HEAD   = "HEAD";
  localparam logic [23:0] MTH_PUT    = "PUT";
  localparam logic [47:0] MTH_DELETE = "DELETE";

  // packet summary handed from the front to the back at the last byte
  typedef struct packed {
    logic        over;
    logic [16:0] len;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [7:0]  ttl;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [3:0]  thw;
    logic [47:0] head;
  } iphpc_summary_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  kind;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  hop_limit;
    logic        outbound;
    logic [6:0]  header_length;
    logic [15:0] payload_length;
    logic [1:0]  app_class;
  } iphpc_result_t;

  function automatic logic method_hit(input logic [47:0] head, input logic [16:0] plen);
    method_hit = (plen >= 17'd3 && head[47:24] == MTH_GET)  ||
                 (plen >= 17'd4 && head[47:16] == MTH_POST) ||
                 (plen >= 17'd4 && head[47:16] == MTH_HEAD) ||
                 (plen >= 17'd3 && head[47:24] == MTH_PUT)  ||
                 (plen >= 17'd6 && head == MTH_DELETE);
  endfunction

endpackage

// ===== src/iphpc_front.sv =====
// byte front end: counts bytes, captures header fields, emits a packet summary at the last byte
// depends on iphpc_pkg
module iphpc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_last_byte,
  output logic                     push,
  output iphpc_pkg::iphpc_summary_t summary
);

  logic [15:0] pos_r, pos_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [31:0] sa_r, sa_nxt;
  logic [31:0] da_r, da_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] dp_r, dp_nxt;
  logic [3:0]  thw_r, thw_nxt;
  logic [47:0] head_r, head_nxt;

  logic        accept;
  logic        l4_on;
  logic        is_tcp;
  logic [16:0] pos17;
  logic [16:0] off;
  logic [16:0] rel;
  logic        past_off;
  logic        have_start;
  logic [16:0] pstart;
  logic [16:0] prel;

  always_comb begin
    accept = in_valid && !in_stall;
    pos17  = {1'b0, pos_r};

    ver_nxt   = (pos_r == 16'd0) ? in_data_byte[7:4] : ver_r;
    ihl_nxt   = (pos_r == 16'd0) ? (in_data_byte[3:0] & iphpc_pkg::NIBBLE_MASK) : ihl_r;
    ttl_nxt   = (pos_r == 16'd8) ? in_data_byte : ttl_r;
    proto_nxt = (pos_r == 16'd9) ? in_data_byte : proto_r;
    sa_nxt    = (pos_r >= 16'd12 && pos_r < 16'd16) ? {sa_r[23:0], in_data_byte} : sa_r;
    da_nxt    = (pos_r >= 16'd16 && pos_r < 16'd20) ? {da_r[23:0], in_data_byte} : da_r;

    l4_on  = (ver_nxt == iphpc_pkg::IP_VER4) && (ihl_nxt >= 4'd5) &&
             (proto_nxt == iphpc_pkg::PROTO_TCP || proto_nxt == iphpc_pkg::PROTO_UDP);
    is_tcp = (proto_nxt == iphpc_pkg::PROTO_TCP);

    off      = {11'd0, ihl_nxt, 2'b00};
    past_off = (pos17 >= off);
    rel      = pos17 - off;

    sp_nxt = sp_r;
    dp_nxt = dp_r;
    thw_nxt = thw_r;
    head_nxt = head_r;
    have_start = 1'b0;
    pstart = '0;
    prel = '0;
    if (l4_on) begin
      if (past_off && rel < 17'd2) begin
        sp_nxt = {sp_r[7:0], in_data_byte};
      end else if (past_off && rel >= 17'd2 && rel < 17'd4) begin
        dp_nxt = {dp_r[7:0], in_data_byte};
      end
      if (is_tcp) begin
        if (past_off && rel == 17'd12) begin
          thw_nxt = in_data_byte[7:4];
        end
        have_start = (thw_nxt >= 4'd5);
        pstart = off + {11'd0, thw_nxt, 2'b00};
      end else begin
        have_start = 1'b1;
        pstart = off + 17'd8;
      end
      prel = pos17 - pstart;
      if (have_start && pos17 >= pstart && prel < 17'd6) begin
        case (prel[2:0])
          3'd0:    head_nxt[47:40] = head_r[47:40] | in_data_byte;
          3'd1:    head_nxt[39:32] = head_r[39:32] | in_data_byte;
          3'd2:    head_nxt[31:24] = head_r[31:24] | in_data_byte;
          3'd3:    head_nxt[23:16] = head_r[23:16] | in_data_byte;
          3'd4:    head_nxt[15:8]  = head_r[15:8]  | in_data_byte;
          default: head_nxt[7:0]   = head_r[7:0]   | in_data_byte;
        endcase
      end
    end

    pos_nxt = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;

    push = accept && in_last_byte;
    summary.over     = (pos17 >= 17'(iphpc_pkg::MAX_PACKET_BYTES));
    summary.len      = pos17 + 17'd1;
    summary.ver      = ver_nxt;
    summary.ihl      = ihl_nxt;
    summary.proto    = proto_nxt;
    summary.ttl      = ttl_nxt;
    summary.src_addr = sa_nxt;
    summary.dst_addr = da_nxt;
    summary.src_port = sp_nxt;
    summary.dst_port = dp_nxt;
    summary.thw      = thw_nxt;
    summary.head     = head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      pos_r   <= '0;
      ver_r   <= '0;
      ihl_r   <= '0;
      proto_r <= '0;
      ttl_r   <= '0;
      sa_r    <= '0;
      da_r    <= '0;
      sp_r    <= '0;
      dp_r    <= '0;
      thw_r   <= '0;
      head_r  <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      ver_r   <= ver_nxt;
      ihl_r   <= ihl_nxt;
      proto_r <= proto_nxt;
      ttl_r   <= ttl_nxt;
      sa_r    <= sa_nxt;
      da_r    <= da_nxt;
      sp_r    <= sp_nxt;
      dp_r    <= dp_nxt;
      thw_r   <= thw_nxt;
      head_r  <= head_nxt;
    end
  end

endmodule

// ===== src/iphpc_queue.sv =====
// two-entry summary queue between the front and the back
// depends on iphpc_pkg
module iphpc_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  iphpc_pkg::iphpc_summary_t wr_data,
  output logic                     full,
  input  logic                     rd_en,
  output iphpc_pkg::iphpc_summary_t rd_data,
  output logic                     empty
);

  iphpc_pkg::iphpc_summary_t mem_r [iphpc_pkg::QUEUE_DEPTH];
  logic [iphpc_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [iphpc_pkg::QUEUE_AW:0]   count_r, count_nxt;
  logic do_wr, do_rd;

  always_comb begin
    full    = (count_r == (iphpc_pkg::QUEUE_AW + 1)'(iphpc_pkg::QUEUE_DEPTH));
    empty   = (count_r == '0);
    do_wr   = wr_en && !full;
    do_rd   = rd_en && !empty;
    rd_data = mem_r[rd_ptr_r];
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/iphpc_back.sv =====
// back end: validates lengths, classifies the packet and holds the result register
// depends on iphpc_pkg
module iphpc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  iphpc_pkg::iphpc_summary_t q_data,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic [15:0]               web_port,
  input  logic [15:0]               secure_web_port,
  input  logic                      out_stall,
  output logic                      out_valid,
  output iphpc_pkg::iphpc_result_t  result
);

  logic                     out_valid_r, out_valid_nxt;
  iphpc_pkg::iphpc_result_t res_r, res_nxt;

  logic        err;
  logic [16:0] off;
  logic [16:0] tcp_len;
  logic [16:0] hdr;
  logic [16:0] pl;
  logic [2:0]  kind;
  logic [1:0]  app;
  logic        has_ports;

  always_comb begin
    off     = {11'd0, q_data.ihl, 2'b00};
    tcp_len = {11'd0, q_data.thw, 2'b00};
    err       = q_data.over || (q_data.len < 17'd20);
    hdr       = '0;
    pl        = '0;
    kind      = iphpc_pkg::KIND_UNKNOWN;
    app       = iphpc_pkg::APP_NONE;
    has_ports = 1'b0;

    if (!err && q_data.ver == iphpc_pkg::IP_VER6) begin
      kind = iphpc_pkg::KIND_V6;
      if (secure_web_port == 16'd0) begin
        app = iphpc_pkg::APP_SECURE;
      end
    end else if (!err && q_data.ver == iphpc_pkg::IP_VER4) begin
      if (q_data.ihl < 4'd5 || q_data.len < off) begin
        err = 1'b1;
      end else if (q_data.proto == iphpc_pkg::PROTO_TCP) begin
        hdr = off + tcp_len;
        if (q_data.len < off + 17'd20 || q_data.thw < 4'd5 || q_data.len < hdr) begin
          err = 1'b1;
        end else begin
          pl        = q_data.len - hdr;
          kind      = (pl != '0) ? iphpc_pkg::KIND_TCP_DATA : iphpc_pkg::KIND_TCP;
          has_ports = 1'b1;
        end
      end else if (q_data.proto == iphpc_pkg::PROTO_UDP) begin
        hdr = off + 17'd8;
        if (q_data.len < hdr) begin
          err = 1'b1;
        end else begin
          pl        = q_data.len - hdr;
          kind      = (pl != '0) ? iphpc_pkg::KIND_UDP_DATA : iphpc_pkg::KIND_UNKNOWN;
          has_ports = 1'b1;
        end
      end else begin
        hdr = off;
      end
      if (!err) begin
        if (kind == iphpc_pkg::KIND_TCP_DATA && q_data.dst_port == web_port &&
            iphpc_pkg::method_hit(q_data.head, pl)) begin
          app = iphpc_pkg::APP_WEB;
        end else if ((kind == iphpc_pkg::KIND_TCP || kind == iphpc_pkg::KIND_TCP_DATA) &&
                     q_data.dst_port == secure_web_port) begin
          app = iphpc_pkg::APP_SECURE;
        end
      end
    end else begin
      err = 1'b1;
    end

    res_nxt = '0;
    if (err) begin
      res_nxt.status = iphpc_pkg::STATUS_ERR;
    end else begin
      res_nxt.status    = iphpc_pkg::STATUS_OK;
      res_nxt.kind      = kind;
      res_nxt.app_class = app;
      if (q_data.ver == iphpc_pkg::IP_VER4) begin
        res_nxt.source_address = q_data.src_addr;
        res_nxt.dest_address   = q_data.dst_addr;
        res_nxt.hop_limit      = q_data.ttl;
        res_nxt.outbound       = (q_data.src_addr < q_data.dst_addr);
        res_nxt.header_length  = hdr[6:0];
        res_nxt.payload_length = pl[15:0];
        if (has_ports) begin
          res_nxt.source_port = q_data.src_port;
          res_nxt.dest_port   = q_data.dst_port;
        end
      end
    end

    q_pop = !q_empty && (!out_valid_r || !out_stall);
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    out_valid = out_valid_r;
    result    = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== src/ipv4_header_parse_classify_unit.sv =====
// ipv4 header parser and classifier: one byte per cycle, back to back, unless stalled
// summary queued at the last byte; result registered when popped, then held under stall
// a two-entry queue sits between the byte front end and the classifier, so bytes keep flowing
// while a result waits; bytes stall only when two finished packets are queued
// reset clears the parse state, sets web_port to 80 and secure_web_port to 443
// depends on iphpc_pkg, iphpc_front, iphpc_queue, iphpc_back
module ipv4_header_parse_classify_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [2:0]  out_kind,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [7:0]  out_hop_limit,
  output logic        out_outbound,
  output logic [6:0]  out_header_length,
  output logic [15:0] out_payload_length,
  output logic [1:0]  out_app_class,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] web_port_r;
  logic [15:0] secure_web_port_r;
  logic        cfg_wr;

  logic                      push;
  iphpc_pkg::iphpc_summary_t summary;
  iphpc_pkg::iphpc_summary_t q_data;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_pop;
  iphpc_pkg::iphpc_result_t  result;

  always_comb begin
    pready = 1'b1;
    cfg_wr = psel && penable && pwrite;
    unique case (paddr[2])
      iphpc_pkg::REG_WEB_PORT:        prdata = {16'd0, web_port_r};
      iphpc_pkg::REG_SECURE_WEB_PORT: prdata = {16'd0, secure_web_port_r};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      web_port_r        <= iphpc_pkg::WEB_PORT_RST;
      secure_web_port_r <= iphpc_pkg::SECURE_WEB_PORT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == iphpc_pkg::REG_WEB_PORT) begin
        web_port_r <= pwdata[15:0];
      end else begin
        secure_web_port_r <= pwdata[15:0];
      end
    end
  end

  assign in_stall = q_full;

  iphpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .summary      (summary)
  );

  iphpc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (summary),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  iphpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_data),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .web_port        (web_port_r),
    .secure_web_port (secure_web_port_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .result          (result)
  );

  assign out_status         = result.status;
  assign out_kind           = result.kind;
  assign out_source_address = result.source_address;
  assign out_dest_address   = result.dest_address;
  assign out_source_port    = result.source_port;
  assign out_dest_port      = result.dest_port;
  assign out_hop_limit      = result.hop_limit;
  assign out_outbound       = result.outbound;
  assign out_header_length  = result.header_length;
  assign out_payload_length = result.payload_length;
  assign out_app_class      = result.app_class;

endmodule
